FILE: sv/tdr_pkg.sv
// Shared constants and types for the turbulence dissipation reduction block.
// Used by tdr_divsqrt and turbulence_dissipation_reduction; depends on nothing.
package tdr_pkg;

	// Default accumulator width, Q24.24.
	localparam int ACC_BITS_DEF = 48;

	// Configuration register indexes.
	localparam logic [1:0] REG_HEAT_RATIO = 2'd0;
	localparam logic [1:0] REG_DIMENSIONS = 2'd1;

	// Register reset values.
	localparam logic [17:0] HEAT_RESET = 18'd91750;
	localparam logic [1:0]  DIM_RESET  = 2'd3;
	localparam logic [1:0]  DIM_3D     = 2'd3;

	// Sutherland constants: 1.402 and 0.40417 in Q.16.
	localparam logic [16:0] SUTH_K = 17'd91881;
	localparam logic [20:0] SUTH_C = 21'd26488;

	// Saturation limits of the result fields.
	localparam logic [23:0] MACH_MAX = 24'hFF_FFFF;
	localparam logic [47:0] OUT_MAX  = 48'hFFFF_FFFF_FFFF;

	// Iteration counts of the shared divide and root unit.
	localparam logic [5:0] STEPS_SQRT_T = 6'd18;
	localparam logic [5:0] STEPS_DIV_S  = 6'd19;
	localparam logic [5:0] STEPS_DIV_M  = 6'd48;
	localparam logic [5:0] STEPS_SQRT_M = 6'd24;

	// Request from the sequencer to the divide and root unit.
	typedef struct packed {
		logic       start;
		logic       is_sqrt;
		logic [5:0] steps;
	} tdr_req_t;

endpackage

FILE: sv/tdr_divsqrt.sv
// Shared bit-serial restoring divider and integer square root.
// Depends on tdr_pkg for the request struct.
module tdr_divsqrt
	import tdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tdr_req_t    req,
	input  logic [39:0] rem_init,
	input  logic [47:0] bits_init,
	input  logic [37:0] divisor,
	output logic        busy,
	output logic [47:0] result
);

	logic        busy_q;
	logic        sqrt_q;
	logic [5:0]  count_q;
	logic [39:0] rem_q;
	logic [47:0] bits_q;
	logic [47:0] quo_q;
	logic [37:0] den_q;

	logic [40:0] op_a;
	logic [40:0] op_b;
	logic [41:0] diff;
	logic        ge;

	// One compare and subtract, shared by both modes.
	always_comb begin
		if (sqrt_q) begin
			op_a = {rem_q[38:0], bits_q[47:46]};
			op_b = {quo_q[38:0], 2'b01};
		end else begin
			op_a = {rem_q, bits_q[47]};
			op_b = {3'b000, den_q};
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = ~diff[41];
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			count_q <= req.steps;
		end else if (busy_q) begin
			count_q <= count_q - 6'd1;
			if (count_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder, operand bits and quotient or root.
	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.is_sqrt;
			rem_q  <= req.is_sqrt ? 40'd0 : rem_init;
			bits_q <= bits_init;
			quo_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[39:0] : op_a[39:0];
			bits_q <= sqrt_q ? {bits_q[45:0], 2'b00} : {bits_q[46:0], 1'b0};
			quo_q  <= {quo_q[46:0], ge};
		end
	end

	assign busy   = busy_q;
	assign result = quo_q;

	// The sequencer never restarts a running operation.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divsqrt restarted while busy");

	// A division keeps its partial remainder below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !sqrt_q) |-> ({2'b00, rem_q} < {4'b0000, den_q}))
		else $error("divsqrt remainder out of range");

	// The last iteration frees the unit.
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && count_q == 6'd1 && !req.start) |=> !busy_q)
		else $error("divsqrt did not finish");

endmodule

FILE: sv/turbulence_dissipation_reduction.sv
// Top level of the turbulence dissipation reduction block.
// Depends on tdr_pkg and tdr_divsqrt.

// Each beat on the input carries one quadrature point. The block holds in_ready
// low from a point's beat until it is through with that point, so it takes no
// new point while one is in work; the Mach division and root are skipped when
// the local Mach number saturates. A bit-serial divide and root unit does the
// root of T (18 iterations), the Sutherland division (19), the Mach division
// (48) and the Mach root (24), and a single 44 by 24 multiplier, one product a
// cycle, runs alongside under the same sequencer. A point flagged last_point
// yields one result beat with the totals and clears the accumulators; a result
// waiting on out_ready stalls the block only when the next totals are due.
// Configuration writes must come only while idle; the block does not enforce it.
module turbulence_dissipation_reduction
	import tdr_pkg::*;
#(
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [59:0] grad_of_ux,
	input  logic [59:0] grad_of_uy,
	input  logic [59:0] grad_of_uz,
	input  logic [59:0] velocity,
	input  logic [19:0] temperature,
	input  logic [23:0] weight,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] dilatation_sum,
	output logic [47:0] solenoidal_sum,
	output logic [23:0] peak_mach,
	output logic [47:0] energy_sum
);

	localparam int SW = ((ACC_BITS > 48) ? ACC_BITS : 48) + 1;
	localparam logic [SW-1:0] ACC_MAX = (SW'(1) << ACC_BITS) - SW'(1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_SQ_D, ST_SQ_V0, ST_SQ_V1, ST_SQ_V2, ST_SUM_V,
		ST_SQ_U0, ST_SQ_U1, ST_SQ_U2, ST_SUM_U, ST_GT, ST_TW, ST_WAIT_T,
		ST_TS, ST_NUM, ST_DIV_S, ST_WAIT_S, ST_PD, ST_PDH, ST_PDL, ST_ACC_D,
		ST_PV, ST_PVH, ST_PVL, ST_ACC_V, ST_MACH, ST_WAIT_Q, ST_WAIT_M, ST_FIN
	} state_t;

	state_t state_q;

	logic [17:0] heat_q;
	logic [1:0]  dim_q;
	logic [ACC_BITS-1:0] dil_acc_q;
	logic [ACC_BITS-1:0] sol_acc_q;
	logic [ACC_BITS-1:0] eng_acc_q;
	logic [23:0] peak_q;
	logic        out_valid_q;
	logic [47:0] dil_out_q;
	logic [47:0] sol_out_q;
	logic [23:0] mach_out_q;
	logic [47:0] eng_out_q;

	// Captured point and intermediate values.
	logic [59:0] gx_q, gy_q, gz_q, vel_q;
	logic [19:0] t_q;
	logic [23:0] w_q;
	logic        last_q;
	logic [21:0] dmag_q;
	logic [20:0] vmag_q [3];
	logic [19:0] umag_q [3];
	logic [41:0] div2_q, vort_q, sqa_q, sqb_q;
	logic [39:0] usq_q;
	logic [37:0] gt_q;
	logic [43:0] ew_q;
	logic [17:0] sqt_q;
	logic [37:0] ts_q;
	logic [54:0] num_q;
	logic [18:0] s_q;
	logic [60:0] p_q, ph_q;
	logic [47:0] pl_q;

	logic        three;
	logic        in_fire;
	logic        out_free;
	logic [43:0] mul_a;
	logic [23:0] mul_b;
	logic [67:0] mul_p;
	tdr_req_t    ds_req;
	logic [39:0] ds_rem;
	logic [47:0] ds_bits;
	logic [37:0] ds_den;
	logic        ds_busy;
	logic [47:0] ds_res;
	logic [61:0] wsum;
	logic [47:0] w_term;
	logic [47:0] e_term;
	logic        mach_sat;

	function automatic logic signed [19:0] comp(input logic [59:0] p, input int k);
		return $signed(p[20*k +: 20]);
	endfunction

	function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] acc,
			input logic [47:0] c);
		logic [SW-1:0] s;
		s = SW'(acc) + SW'(c);
		return (s > ACC_MAX) ? ACC_MAX[ACC_BITS-1:0] : s[ACC_BITS-1:0];
	endfunction

	function automatic logic [47:0] clamp48(input logic [ACC_BITS-1:0] acc);
		logic [SW-1:0] x;
		x = SW'(acc);
		return (x > SW'(OUT_MAX)) ? OUT_MAX : x[47:0];
	endfunction

	assign three    = (dim_q == DIM_3D);
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// The shared multiplier, one product a cycle, always into a register.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q) inside
			ST_SQ_D:  begin mul_a = 44'(dmag_q);     mul_b = 24'(dmag_q);    end
			ST_SQ_V0: begin mul_a = 44'(vmag_q[0]);  mul_b = 24'(vmag_q[0]); end
			ST_SQ_V1: begin mul_a = 44'(vmag_q[1]);  mul_b = 24'(vmag_q[1]); end
			ST_SQ_V2: begin mul_a = 44'(vmag_q[2]);  mul_b = 24'(vmag_q[2]); end
			ST_SQ_U0: begin mul_a = 44'(umag_q[0]);  mul_b = 24'(umag_q[0]); end
			ST_SQ_U1: begin mul_a = 44'(umag_q[1]);  mul_b = 24'(umag_q[1]); end
			ST_SQ_U2: begin mul_a = 44'(umag_q[2]);  mul_b = 24'(umag_q[2]); end
			ST_GT:    begin mul_a = 44'(t_q);        mul_b = 24'(heat_q);    end
			ST_TW:    begin mul_a = 44'(t_q);        mul_b = w_q;            end
			ST_TS:    begin mul_a = 44'(t_q);        mul_b = 24'(sqt_q);     end
			ST_NUM:   begin mul_a = 44'(ts_q);       mul_b = 24'(SUTH_K);    end
			ST_PD:    begin mul_a = 44'(div2_q);     mul_b = 24'(s_q);       end
			ST_PV:    begin mul_a = 44'(vort_q);     mul_b = 24'(s_q);       end
			ST_PDH, ST_PVH: begin mul_a = 44'(p_q[60:24]); mul_b = w_q;      end
			ST_PDL, ST_PVL: begin mul_a = 44'(p_q[23:0]);  mul_b = w_q;      end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = {24'd0, mul_a} * {44'd0, mul_b};

	// Requests to the divide and root unit.
	assign mach_sat = (gt_q == 38'd0) || ({6'd0, usq_q} >= {gt_q, 8'd0});
	always_comb begin
		ds_req  = '0;
		ds_rem  = '0;
		ds_bits = '0;
		ds_den  = '0;
		unique case (state_q)
			ST_PREP: begin
				ds_req  = '{start: 1'b1, is_sqrt: 1'b1, steps: STEPS_SQRT_T};
				ds_bits = {t_q, 28'd0};
			end
			ST_DIV_S: begin
				ds_req  = '{start: 1'b1, is_sqrt: 1'b0, steps: STEPS_DIV_S};
				ds_rem  = 40'(num_q[54:19]);
				ds_bits = {num_q[18:0], 29'd0};
				ds_den  = 38'({(SUTH_C + 21'(t_q)), 16'd0});
			end
			ST_MACH: begin
				ds_req  = '{start: !mach_sat, is_sqrt: 1'b0, steps: STEPS_DIV_M};
				ds_rem  = 40'(usq_q[39:8]);
				ds_bits = {usq_q[7:0], 40'd0};
				ds_den  = gt_q;
			end
			ST_WAIT_Q: begin
				ds_req  = '{start: !ds_busy, is_sqrt: 1'b1, steps: STEPS_SQRT_M};
				ds_bits = ds_res;
			end
			default: ds_req = '0;
		endcase
	end

	tdr_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ds_req),
		.rem_init  (ds_rem),
		.bits_init (ds_bits),
		.divisor   (ds_den),
		.busy      (ds_busy),
		.result    (ds_res)
	);

	// Weighted terms: floor(p * w / 2^40) and (T * w) >> 16.
	assign wsum   = {1'b0, ph_q} + 62'(pl_q[47:24]);
	assign w_term = 48'(wsum[61:16]);
	assign e_term = 48'(ew_q[43:16]);

	// Sequencer, configuration, accumulators and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			heat_q      <= HEAT_RESET;
			dim_q       <= DIM_RESET;
			dil_acc_q   <= '0;
			sol_acc_q   <= '0;
			eng_acc_q   <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAT_RATIO: heat_q <= cfg_wdata;
					REG_DIMENSIONS: dim_q  <= cfg_wdata[1:0];
					default: ;
				endcase
			end
			// A taken result beat frees the register unless new totals load it.
			if (out_valid_q && out_ready && !(state_q == ST_FIN && last_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (in_fire) state_q <= ST_PREP;
				ST_PREP:   state_q <= ST_SQ_D;
				ST_SQ_D:   state_q <= ST_SQ_V0;
				ST_SQ_V0:  state_q <= ST_SQ_V1;
				ST_SQ_V1:  state_q <= ST_SQ_V2;
				ST_SQ_V2:  state_q <= ST_SUM_V;
				ST_SUM_V:  state_q <= ST_SQ_U0;
				ST_SQ_U0:  state_q <= ST_SQ_U1;
				ST_SQ_U1:  state_q <= ST_SQ_U2;
				ST_SQ_U2:  state_q <= ST_SUM_U;
				ST_SUM_U:  state_q <= ST_GT;
				ST_GT:     state_q <= ST_TW;
				ST_TW:     state_q <= ST_WAIT_T;
				ST_WAIT_T: if (!ds_busy) state_q <= ST_TS;
				ST_TS:     state_q <= ST_NUM;
				ST_NUM:    state_q <= ST_DIV_S;
				ST_DIV_S:  state_q <= ST_WAIT_S;
				ST_WAIT_S: if (!ds_busy) state_q <= ST_PD;
				ST_PD:     state_q <= ST_PDH;
				ST_PDH:    state_q <= ST_PDL;
				ST_PDL:    state_q <= ST_ACC_D;
				ST_ACC_D: begin
					dil_acc_q <= sat_add(dil_acc_q, w_term);
					eng_acc_q <= sat_add(eng_acc_q, e_term);
					state_q   <= ST_PV;
				end
				ST_PV:     state_q <= ST_PVH;
				ST_PVH:    state_q <= ST_PVL;
				ST_PVL:    state_q <= ST_ACC_V;
				ST_ACC_V: begin
					sol_acc_q <= sat_add(sol_acc_q, w_term);
					state_q   <= ST_MACH;
				end
				ST_MACH: begin
					if (mach_sat) begin
						peak_q  <= MACH_MAX;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WAIT_Q;
					end
				end
				ST_WAIT_Q: if (!ds_busy) state_q <= ST_WAIT_M;
				ST_WAIT_M: begin
					if (!ds_busy) begin
						if (ds_res[23:0] > peak_q) peak_q <= ds_res[23:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						dil_acc_q   <= '0;
						sol_acc_q   <= '0;
						eng_acc_q   <= '0;
						peak_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			gx_q   <= grad_of_ux;
			gy_q   <= grad_of_uy;
			gz_q   <= grad_of_uz;
			vel_q  <= velocity;
			t_q    <= temperature;
			w_q    <= weight;
			last_q <= last_point;
		end
		case (state_q) inside
			ST_PREP: begin
				// Divergence, vorticity and velocity magnitudes; z terms drop in 2D.
				logic signed [21:0] d;
				logic signed [20:0] v0, v1, v2;
				d  = 22'(comp(gx_q, 0)) + 22'(comp(gy_q, 1))
					+ (three ? 22'(comp(gz_q, 2)) : 22'sd0);
				v0 = 21'(comp(gy_q, 0)) - 21'(comp(gx_q, 1));
				v1 = three ? 21'(comp(gz_q, 1)) - 21'(comp(gy_q, 2)) : 21'sd0;
				v2 = three ? 21'(comp(gx_q, 2)) - 21'(comp(gz_q, 0)) : 21'sd0;
				dmag_q    <= d[21] ? 22'(-d) : 22'(d);
				vmag_q[0] <= v0[20] ? 21'(-v0) : 21'(v0);
				vmag_q[1] <= v1[20] ? 21'(-v1) : 21'(v1);
				vmag_q[2] <= v2[20] ? 21'(-v2) : 21'(v2);
				umag_q[0] <= vel_q[19] ? 20'(-vel_q[19:0]) : vel_q[19:0];
				umag_q[1] <= vel_q[39] ? 20'(-vel_q[39:20]) : vel_q[39:20];
				umag_q[2] <= !three ? 20'd0
					: (vel_q[59] ? 20'(-vel_q[59:40]) : vel_q[59:40]);
			end
			ST_SQ_D:   div2_q <= mul_p[41:0];
			ST_SQ_V0:  vort_q <= mul_p[41:0];
			ST_SQ_V1:  sqa_q  <= mul_p[41:0];
			ST_SQ_V2:  sqb_q  <= mul_p[41:0];
			ST_SUM_V:  vort_q <= vort_q + sqa_q + sqb_q;
			ST_SQ_U0:  usq_q  <= mul_p[39:0];
			ST_SQ_U1:  sqa_q  <= mul_p[41:0];
			ST_SQ_U2:  sqb_q  <= mul_p[41:0];
			ST_SUM_U:  usq_q  <= usq_q + sqa_q[39:0] + sqb_q[39:0];
			ST_GT:     gt_q   <= mul_p[37:0];
			ST_TW:     ew_q   <= mul_p[43:0];
			ST_WAIT_T: sqt_q  <= ds_res[17:0];
			ST_TS:     ts_q   <= mul_p[37:0];
			ST_NUM:    num_q  <= mul_p[54:0];
			ST_WAIT_S: s_q    <= ds_res[18:0];
			ST_PD, ST_PV:   p_q  <= mul_p[60:0];
			ST_PDH, ST_PVH: ph_q <= mul_p[60:0];
			ST_PDL, ST_PVL: pl_q <= mul_p[47:0];
			ST_FIN: begin
				if (last_q && out_free) begin
					dil_out_q  <= clamp48(dil_acc_q);
					sol_out_q  <= clamp48(sol_acc_q);
					mach_out_q <= peak_q;
					eng_out_q  <= clamp48(eng_acc_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign dilatation_sum = dil_out_q;
	assign solenoidal_sum = sol_out_q;
	assign peak_mach      = mach_out_q;
	assign energy_sum     = eng_out_q;

	// An accepted point always starts the sequence.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_PREP) else $error("point not started");

	// Emitting the totals clears the accumulators.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q && out_free) |=>
		(out_valid_q && dil_acc_q == '0 && sol_acc_q == '0 && peak_q == '0))
		else $error("totals not emitted and cleared");

	// The root unit is free whenever the sequencer waits for a new point.
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ds_busy) else $error("unit busy while idle");

endmodule
